// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define BMG_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("same-cycle check failed");

// Condition c must hold in the cycle after a.
`define BMG_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

// File: hw/rtl/bmg_pkg.sv
`timescale 1ns / 1ps
package bmg_pkg;

	// Default width of the uniform input codes.
	localparam int UNIFORM_BITS_DEF = 24;

	// Configuration port geometry.
	localparam int STD_W     = 24;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STD_SCALE   = 1'b0,
		REG_MEAN_OFFSET = 1'b1
	} reg_idx_t;

	localparam logic [STD_W-1:0]  STD_RESET  = 24'd65536;
	localparam logic [DATA_W-1:0] MEAN_RESET = 32'd0;

	// Fixed-point constants.
	localparam logic [28:0] LN2X2_Q28  = 29'd372130559;
	localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE30      = 31'h4000_0000;

	// Internal widths.
	localparam int FRAC_W = 30;
	localparam int S_W    = 36;
	localparam int ROOT_W = 31;
	localparam int MAG_W  = 33;
	localparam int TRIG_W = 31;
	localparam int ABS_W  = 28;

	// Latency of each pipeline section in cycles.
	localparam int LOG_LAT   = 34;
	localparam int SQRT_LAT  = 31;
	localparam int MAG_LAT   = 1;
	localparam int TRIG_LAT  = 19;
	localparam int FIN_LAT   = 3;
	localparam int TRIG_DLY  = LOG_LAT + SQRT_LAT + MAG_LAT - TRIG_LAT;
	localparam int TOTAL_LAT = LOG_LAT + SQRT_LAT + MAG_LAT + FIN_LAT;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Trig magnitudes and signs for both outputs.
	typedef struct packed {
		logic [TRIG_W-1:0] cmag;
		logic              cneg;
		logic [TRIG_W-1:0] smag;
		logic              sneg;
	} trig_t;

endpackage

// File: hw/rtl/bmg_log.sv
`timescale 1ns / 1ps
module bmg_log #(
	parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [UNIFORM_BITS-1:0]   radius,
	output logic [bmg_pkg::S_W-1:0]   neg2ln
);
	import bmg_pkg::*;

	localparam int PW = $clog2(UNIFORM_BITS);
	localparam int KW = $clog2(UNIFORM_BITS + 1);
	localparam longint UMIN_RAW = ((longint'(1) << UNIFORM_BITS) + 5000000) / 10000000;
	localparam logic [UNIFORM_BITS-1:0] UMIN =
		(UMIN_RAW < 1) ? UNIFORM_BITS'(1) : UNIFORM_BITS'(UMIN_RAW);
	localparam int STEPS = FRAC_W;

	logic [UNIFORM_BITS-1:0]    x_c;
	logic [PW-1:0]              p_c;
	logic [UNIFORM_BITS-1:0]    xn_c;
	logic [UNIFORM_BITS+30:0]   ext_c;

	logic [30:0]       m_s [0:STEPS];
	logic [FRAC_W-1:0] f_s [0:STEPS];
	logic [KW-1:0]     k_s [0:STEPS];

	logic [S_W-1:0]  t_s31;
	logic [46:0]     hi_s32;
	logic [46:0]     lo_s32;
	logic [65:0]     sum_c;

	// Floor the code, find its top bit and normalize the mantissa to Q1.30.
	always_comb begin
		x_c = (radius < UMIN) ? UMIN : radius;
		p_c = '0;
		for (int i = 0; i < UNIFORM_BITS; i++) begin
			if (x_c[i]) begin
				p_c = PW'(i);
			end
		end
		xn_c  = x_c << (PW'(UNIFORM_BITS - 1) - p_c);
		ext_c = {xn_c, 31'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= ext_c[UNIFORM_BITS+30 -: 31];
			f_s[0] <= '0;
			k_s[0] <= KW'(UNIFORM_BITS) - KW'(p_c);
		end
	end

	// One squaring per stage yields one fraction bit of log2.
	for (genvar i = 1; i <= STEPS; i++) begin : g_sq
		logic [61:0] prod;
		logic [31:0] sq;

		always_comb begin
			prod = 62'(m_s[i-1]) * 62'(m_s[i-1]);
			sq   = prod[61:30];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i] <= sq[31] ? sq[31:1] : sq[30:0];
				f_s[i] <= f_s[i-1] | (sq[31] ? (FRAC_W'(1) << (STEPS - i)) : '0);
				k_s[i] <= k_s[i-1];
			end
		end
	end

	// Scale -log2 by 2 ln 2 with two partial products.
	assign sum_c = {1'b0, hi_s32, 18'd0} + 66'(lo_s32);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s31  <= (S_W'(k_s[STEPS]) << FRAC_W) - S_W'(f_s[STEPS]);
			hi_s32 <= 47'(t_s31[35:18]) * 47'(LN2X2_Q28);
			lo_s32 <= 47'(t_s31[17:0]) * 47'(LN2X2_Q28);
			neg2ln <= sum_c[63:28];
		end
	end

endmodule

// File: hw/rtl/bmg_sqrt.sv
`timescale 1ns / 1ps
module bmg_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [bmg_pkg::S_W-1:0]     radicand,
	output logic [bmg_pkg::ROOT_W-1:0]  root
);
	import bmg_pkg::*;

	localparam int V_W   = 2 * ROOT_W;
	localparam int REM_W = 34;

	logic [V_W-1:0]    v_s    [0:ROOT_W-1];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];

	// Restoring square root, one result bit per stage.
	for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
		logic [V_W-1:0]    v_prev;
		logic [REM_W-1:0]  rem_prev;
		logic [ROOT_W-1:0] root_prev;
		logic [REM_W-1:0]  rem_t;
		logic [REM_W-1:0]  trial;

		if (i == 0) begin : g_first
			assign v_prev    = {radicand, 26'd0};
			assign rem_prev  = '0;
			assign root_prev = '0;
		end else begin : g_next
			assign v_prev    = v_s[i-1];
			assign rem_prev  = rem_s[i-1];
			assign root_prev = root_s[i-1];
		end

		always_comb begin
			rem_t = {rem_prev[REM_W-3:0], v_prev[V_W-1-2*i -: 2]};
			trial = REM_W'({root_prev, 2'b01});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i] <= v_prev;
				if (rem_t >= trial) begin
					rem_s[i]  <= rem_t - trial;
					root_s[i] <= {root_prev[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= rem_t;
					root_s[i] <= {root_prev[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

// File: hw/rtl/bmg_horner.sv
`timescale 1ns / 1ps
module bmg_horner #(
	parameter int DIV = 2
) (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] t2_in,
	input  logic [30:0] a_in,
	output logic [29:0] t2_out,
	output logic [30:0] a_out
);
	import bmg_pkg::*;

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

	logic [60:0] n_prod;
	logic [62:0] q_prod;
	logic [30:0] n_s1, n_s2, q0_s2;
	logic [29:0] t2_s1, t2_s2;
	logic [30:0] rem_c, quo_c;

	// Horner step: a_out = 1 - (t2 * a_in) / DIV, all truncated.
	always_comb begin
		n_prod = 61'(t2_in) * 61'(a_in);
		q_prod = 63'(n_s1) * 63'(RECIP);
		rem_c  = n_s2 - 31'(38'(q0_s2) * 38'(DIV));
		quo_c  = (rem_c >= 31'(DIV)) ? q0_s2 + 31'd1 : q0_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= n_prod[60:30];
			t2_s1  <= t2_in;
			q0_s2  <= q_prod[62:32];
			n_s2   <= n_s1;
			t2_s2  <= t2_s1;
			a_out  <= ONE30 - quo_c;
			t2_out <= t2_s2;
		end
	end

endmodule

// File: hw/rtl/bmg_sincos.sv
`timescale 1ns / 1ps
module bmg_sincos #(
	parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [UNIFORM_BITS-1:0] angle,
	output bmg_pkg::trig_t          trig
);
	import bmg_pkg::*;

	localparam int COS_N = 5;
	localparam int SIN_N = 4;
	localparam int COS_DIV [COS_N] = '{90, 56, 30, 12, 2};
	localparam int SIN_DIV [SIN_N] = '{72, 42, 20, 6};
	localparam int SIN_TH_DLY = 3 * SIN_N;
	localparam int SIDE_DLY = 3 * COS_N;

	logic [31:0] w_c;
	logic        swap_c;
	logic [60:0] th_prod;
	logic [59:0] t2_prod;
	logic [60:0] sn_prod;

	logic [29:0] x_s1, th_s2, th_s3, t2_s3;
	quad_t       quad_s1, quad_s2, quad_s3;
	logic        swap_s1, swap_s2, swap_s3;

	logic [30:0] cos_a  [0:COS_N];
	logic [29:0] cos_t2 [0:COS_N];
	logic [30:0] sin_a  [0:SIN_N];
	logic [29:0] sin_t2 [0:SIN_N];
	logic [29:0] th_dly [0:SIN_TH_DLY-1];
	quad_t       quad_dly [0:SIDE_DLY-1];
	logic        swap_dly [0:SIDE_DLY-1];

	logic [30:0] sn_s16, sn_s17, sn_s18;
	logic [30:0] cs_c, sn_c;

	// Fold the angle into one eighth of a turn.
	always_comb begin
		w_c    = 32'(angle) << (32 - UNIFORM_BITS);
		swap_c = w_c[29:0] > 30'h2000_0000;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= quad_t'(w_c[31:30]);
			swap_s1 <= swap_c;
			x_s1    <= swap_c ? 30'(31'h4000_0000 - 31'(w_c[29:0])) : w_c[29:0];
		end
	end

	// Radians, then the square of the angle.
	always_comb begin
		th_prod = 61'(x_s1) * 61'(HALFPI_Q30);
		t2_prod = 60'(th_s2) * 60'(th_s2);
		sn_prod = 61'(th_dly[SIN_TH_DLY-1]) * 61'(sin_a[SIN_N]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s2   <= th_prod[59:30];
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
			th_s3   <= th_s2;
			t2_s3   <= t2_prod[59:30];
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;
		end
	end

	// Horner chains for both series.
	assign cos_a[0]  = ONE30;
	assign cos_t2[0] = t2_s3;
	assign sin_a[0]  = ONE30;
	assign sin_t2[0] = t2_s3;

	for (genvar i = 0; i < COS_N; i++) begin : g_cos
		bmg_horner #(.DIV(COS_DIV[i])) u_step (
			.clk    (clk),
			.en     (en),
			.t2_in  (cos_t2[i]),
			.a_in   (cos_a[i]),
			.t2_out (cos_t2[i+1]),
			.a_out  (cos_a[i+1])
		);
	end

	for (genvar i = 0; i < SIN_N; i++) begin : g_sin
		bmg_horner #(.DIV(SIN_DIV[i])) u_step (
			.clk    (clk),
			.en     (en),
			.t2_in  (sin_t2[i]),
			.a_in   (sin_a[i]),
			.t2_out (sin_t2[i+1]),
			.a_out  (sin_a[i+1])
		);
	end

	// Side data travels alongside the series.
	always_ff @(posedge clk) begin
		if (en) begin
			th_dly[0]   <= th_s3;
			quad_dly[0] <= quad_s3;
			swap_dly[0] <= swap_s3;
			for (int j = 1; j < SIN_TH_DLY; j++) begin
				th_dly[j] <= th_dly[j-1];
			end
			for (int j = 1; j < SIDE_DLY; j++) begin
				quad_dly[j] <= quad_dly[j-1];
				swap_dly[j] <= swap_dly[j-1];
			end
			sn_s16 <= sn_prod[60:30];
			sn_s17 <= sn_s16;
			sn_s18 <= sn_s17;
		end
	end

	// Undo the fold, then map the quadrant to magnitudes and signs.
	always_comb begin
		cs_c = swap_dly[SIDE_DLY-1] ? sn_s18 : cos_a[COS_N];
		sn_c = swap_dly[SIDE_DLY-1] ? cos_a[COS_N] : sn_s18;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_dly[SIDE_DLY-1])
				QUAD_0: begin
					trig <= '{cmag: cs_c, cneg: 1'b0, smag: sn_c, sneg: 1'b0};
				end
				QUAD_1: begin
					trig <= '{cmag: sn_c, cneg: 1'b1, smag: cs_c, sneg: 1'b0};
				end
				QUAD_2: begin
					trig <= '{cmag: cs_c, cneg: 1'b1, smag: sn_c, sneg: 1'b1};
				end
				default: begin
					trig <= '{cmag: sn_c, cneg: 1'b0, smag: cs_c, sneg: 1'b1};
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/bmg_finish.sv
`timescale 1ns / 1ps
module bmg_finish (
	input  logic                       clk,
	input  logic                       en,
	input  logic [bmg_pkg::MAG_W-1:0]  mag,
	input  bmg_pkg::trig_t             trig,
	input  logic signed [31:0]         mean,
	output logic signed [31:0]         normal_cos,
	output logic signed [31:0]         normal_sin,
	output logic                       clipped
);
	import bmg_pkg::*;

	logic [46:0]      cl_s1, sl_s1;
	logic [47:0]      ch_s1, sh_s1;
	logic             cneg_s1, sneg_s1, cneg_s2, sneg_s2;
	logic [ABS_W-1:0] cabs_s2, sabs_s2;
	logic [63:0]      csum_c, ssum_c;
	logic [32:0]      cres_c, sres_c;

	// Add the mean to a signed magnitude and clamp to 32 bits; bit 32 flags a clamp.
	function automatic logic [32:0] sat_add(input logic [ABS_W-1:0] mag_abs,
		input logic neg, input logic signed [31:0] ofs);
		logic signed [33:0] v;
		v = neg ? -$signed({6'd0, mag_abs}) : $signed({6'd0, mag_abs});
		v = v + $signed({{2{ofs[31]}}, ofs});
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			sat_add = {1'b0, v[31:0]};
		end else if (v[33]) begin
			sat_add = {1'b1, 32'h8000_0000};
		end else begin
			sat_add = {1'b1, 32'h7fff_ffff};
		end
	endfunction

	// Rounded products from two partial products each.
	always_comb begin
		csum_c = {ch_s1, 16'd0} + 64'(cl_s1) + (64'd1 << 35);
		ssum_c = {sh_s1, 16'd0} + 64'(sl_s1) + (64'd1 << 35);
		cres_c = sat_add(cabs_s2, cneg_s2, mean);
		sres_c = sat_add(sabs_s2, sneg_s2, mean);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cl_s1      <= 47'(mag[15:0]) * 47'(trig.cmag);
			ch_s1      <= 48'(mag[32:16]) * 48'(trig.cmag);
			sl_s1      <= 47'(mag[15:0]) * 47'(trig.smag);
			sh_s1      <= 48'(mag[32:16]) * 48'(trig.smag);
			cneg_s1    <= trig.cneg;
			sneg_s1    <= trig.sneg;
			cabs_s2    <= csum_c[63:36];
			sabs_s2    <= ssum_c[63:36];
			cneg_s2    <= cneg_s1;
			sneg_s2    <= sneg_s1;
			normal_cos <= cres_c[31:0];
			normal_sin <= sres_c[31:0];
			clipped    <= cres_c[32] | sres_c[32];
		end
	end

endmodule

// File: hw/rtl/box_muller_gaussian_pair_core.sv
`timescale 1ns / 1ps
// Box-Muller Gaussian pair generator. Every cycle it can take one pair of uniform codes and
// deliver for it one pair of normal samples in signed Q16.16 together with a saturation
// flag. The depth comes from the logarithm, which squares the mantissa once per stage for
// 30 stages, and the square root, which resolves one result bit per stage over 31 stages;
// the sine and cosine series run alongside. The whole pipeline holds while a finished
// result waits at the output and is not taken, so throughput is one pair per cycle
// whenever the consumer keeps up. Write std_scale and mean_offset only while idle.
module box_muller_gaussian_pair_core #(
	parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [bmg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmg_pkg::DATA_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [UNIFORM_BITS-1:0]           uniform_radius,
	input  logic [UNIFORM_BITS-1:0]           uniform_angle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                normal_cos,
	output logic signed [31:0]                normal_sin,
	output logic                              clipped
);
	import bmg_pkg::*;

	`include "assert_macros.svh"

	logic [STD_W-1:0]     std_q;
	logic signed [31:0]   mean_q;
	logic                 en;
	logic [TOTAL_LAT-1:0] vld_s;
	logic [S_W-1:0]       neg2ln;
	logic [ROOT_W-1:0]    root;
	logic [54:0]          mag_prod;
	logic [MAG_W-1:0]     mag_s66;
	trig_t                trig_res;
	trig_t                trig_dly [0:TRIG_DLY-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q  <= STD_RESET;
			mean_q <= MEAN_RESET;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STD_SCALE:   std_q  <= cfg_wdata[STD_W-1:0];
				REG_MEAN_OFFSET: mean_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless a result waits for a transfer out.
	assign en        = !(out_valid && !out_ready);
	assign in_ready  = en;
	assign out_valid = vld_s[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOTAL_LAT-2:0], in_valid};
		end
	end

	// Radius path: -2 ln u1, then its root.
	bmg_log #(.UNIFORM_BITS(UNIFORM_BITS)) u_log (
		.clk    (clk),
		.en     (en),
		.radius (uniform_radius),
		.neg2ln (neg2ln)
	);

	bmg_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (neg2ln),
		.root     (root)
	);

	// Scale by the standard deviation.
	assign mag_prod = 55'(std_q) * 55'(root);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s66 <= mag_prod[54:22];
		end
	end

	// Angle path, delayed to meet the magnitude.
	bmg_sincos #(.UNIFORM_BITS(UNIFORM_BITS)) u_sincos (
		.clk   (clk),
		.en    (en),
		.angle (uniform_angle),
		.trig  (trig_res)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			trig_dly[0] <= trig_res;
			for (int j = 1; j < TRIG_DLY; j++) begin
				trig_dly[j] <= trig_dly[j-1];
			end
		end
	end

	bmg_finish u_finish (
		.clk        (clk),
		.en         (en),
		.mag        (mag_s66),
		.trig       (trig_dly[TRIG_DLY-1]),
		.mean       (mean_q),
		.normal_cos (normal_cos),
		.normal_sin (normal_sin),
		.clipped    (clipped)
	);

	// A waiting result freezes every stage.
	`BMG_ASSERT_NEXT(a_stall_freezes, out_valid && !out_ready, $stable(vld_s))
	// The flag only comes with an output at a range limit.
	`BMG_ASSERT_NOW(a_clip_at_limit, out_valid && clipped, normal_cos == 32'sh7fffffff || normal_cos == 32'sh80000000 || normal_sin == 32'sh7fffffff || normal_sin == 32'sh80000000)
	// Trig magnitudes never exceed one.
	`BMG_ASSERT_NOW(a_trig_range, vld_s[TRIG_LAT-1], trig_res.cmag <= ONE30 && trig_res.smag <= ONE30)

endmodule
